### hdl/tsp_pkg.sv
package tsp_pkg;

    // Width bounds for the counts and the script lengths.
    localparam int COUNT_BITS = 32;
    localparam int LEN_BITS   = 32;

    // Result queue.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] VARINT_MARK2 = 8'hFD;
    localparam logic [7:0] VARINT_MARK4 = 8'hFE;
    localparam logic [3:0] MIN_BYTES    = 4'd10;
    localparam logic [3:0] SEEN_MAX     = 4'd15;
    localparam int         HASH_BYTES   = 32;

    typedef enum logic [3:0] {
        KIND_VERSION    = 4'd0,
        KIND_IN_COUNT   = 4'd1,
        KIND_HASH       = 4'd2,
        KIND_OUT_INDEX  = 4'd3,
        KIND_SIG_LEN    = 4'd4,
        KIND_SIG_BYTE   = 4'd5,
        KIND_SEQUENCE   = 4'd6,
        KIND_OUT_COUNT  = 4'd7,
        KIND_AMOUNT     = 4'd8,
        KIND_PK_LEN     = 4'd9,
        KIND_PK_BYTE    = 4'd10,
        KIND_LOCK       = 4'd11,
        KIND_END        = 4'd12
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SHORT     = 2'd1,
        ST_TRUNCATED = 2'd2,
        ST_OVERSIZE  = 2'd3
    } status_t;

    typedef enum logic [13:0] {
        PH_VERSION    = 14'b00000000000001,
        PH_IN_COUNT   = 14'b00000000000010,
        PH_HASH       = 14'b00000000000100,
        PH_OUT_INDEX  = 14'b00000000001000,
        PH_SIG_LEN    = 14'b00000000010000,
        PH_SIG_BYTES  = 14'b00000000100000,
        PH_SEQUENCE   = 14'b00000001000000,
        PH_OUT_COUNT  = 14'b00000010000000,
        PH_AMOUNT     = 14'b00000100000000,
        PH_PK_LEN     = 14'b00001000000000,
        PH_PK_BYTES   = 14'b00010000000000,
        PH_LOCK       = 14'b00100000000000,
        PH_DONE       = 14'b01000000000000,
        PH_ERROR      = 14'b10000000000000
    } phase_t;

    typedef struct packed {
        kind_t        kind;
        logic [63:0]  value;
        logic [31:0]  entry;
        logic [31:0]  bytepos;
        status_t      status;
        logic         eor;
    } result_t;

    // True when v does not fit in the given number of bits.
    function automatic logic over_bound(input logic [63:0] v, input int bits);
        logic res;
        res = 1'b0;
        if (bits < 64)
        begin
            res = ((v >> bits) != 64'd0);
        end
        return res;
    endfunction

endpackage

### hdl/transaction_stream_parser_core.sv
// Streaming parser for a serialized legacy transaction.
//
// Input channel: one byte per request on in_byte, with last marking the
// final byte of a transaction. A request is taken when byte_valid is high
// and byte_stall is low. Output channel: one parsed field per request on
// field_kind, field_value, entry_number, byte_number, status and end_of_run,
// taken when field_valid is high and field_stall is low.
//
// Each byte is captured in an input register and parsed from there; its
// results enter a four-entry result queue. The first result of a byte can be
// taken once it has passed the input register and been written to the queue.
// One byte is accepted every cycle while byte_stall is low; a byte yields at
// most one field result, plus the end result when last is set, so the byte
// that closes a transaction can put two results in the queue. The queue
// accepts a parsed byte only while it has room for two results, so a stalled
// receiver backs up into byte_stall after the queue fills; nothing is dropped.
//
// Reset clears the parser to the version field and empties the queue. After
// the end result of a transaction the parser returns to the same state.
module transaction_stream_parser_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  in_byte,
    input  logic        last,
    output logic        field_valid,
    input  logic        field_stall,
    output logic [3:0]  field_kind,
    output logic [63:0] field_value,
    output logic [31:0] entry_number,
    output logic [31:0] byte_number,
    output logic [1:0]  status,
    output logic        end_of_run
);

    // Input register.
    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic        fire;

    // Parser state.
    tsp_pkg::phase_t                phase_reg, phase_next;
    logic [3:0]                     fbp_reg, fbp_next;
    logic [3:0]                     vbl_reg, vbl_next;
    logic [63:0]                    acc_reg, acc_next;
    logic [tsp_pkg::COUNT_BITS-1:0] entries_reg, entries_next;
    logic [31:0]                    entry_idx_reg, entry_idx_next;
    logic [tsp_pkg::LEN_BITS-1:0]   script_left_reg, script_left_next;
    logic [31:0]                    script_pos_reg, script_pos_next;
    logic [3:0]                     seen_reg, seen_next;
    logic                           err_reg, err_next;

    // Results of the byte being parsed.
    logic              fres_valid;
    tsp_pkg::result_t  fres;
    tsp_pkg::result_t  eres;

    // Result queue.
    tsp_pkg::result_t            fifo_mem [tsp_pkg::FIFO_DEPTH];
    logic [tsp_pkg::PTR_W-1:0]   wp_reg, rp_reg;
    logic [tsp_pkg::CNT_W-1:0]   count_reg;
    logic                        pop;
    logic [1:0]                  push_n;
    tsp_pkg::result_t            head;

    // Byte decoding helpers.
    logic [63:0] b64;
    logic [63:0] acc_fixed;
    logic [63:0] acc_var;
    logic [2:0]  lane_var;
    logic        fix_done;
    logic        var_done;
    logic [63:0] var_value;
    logic [3:0]  fbp_inc;

    function automatic logic [tsp_pkg::PTR_W-1:0] ptr_inc(input logic [tsp_pkg::PTR_W-1:0] p);
        logic [tsp_pkg::PTR_W-1:0] r;
        if (p == tsp_pkg::PTR_W'(tsp_pkg::FIFO_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + tsp_pkg::PTR_W'(1);
        end
        return r;
    endfunction

    assign fire       = in_valid_reg && (count_reg <= tsp_pkg::CNT_W'(tsp_pkg::FIFO_DEPTH - 2));
    assign byte_stall = in_valid_reg && !fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            in_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            byte_reg <= in_byte;
            last_reg <= last;
        end
    end

    // Shared pieces of the fixed-field and varint assembly.
    assign b64       = {56'd0, byte_reg};
    assign fbp_inc   = fbp_reg + 4'd1;
    assign acc_fixed = acc_reg | (b64 << {fbp_reg[2:0], 3'b000});
    assign lane_var  = fbp_reg[2:0] - 3'd1;
    assign acc_var   = acc_reg | (b64 << {lane_var, 3'b000});
    assign fix_done  = (phase_reg == tsp_pkg::PH_AMOUNT) ? (fbp_inc >= 4'd8)
                                                          : (fbp_inc >= 4'd4);
    assign var_done  = (fbp_reg == 4'd0) ? (byte_reg < tsp_pkg::VARINT_MARK2)
                                         : (vbl_reg == 4'd1);
    assign var_value = (fbp_reg == 4'd0) ? b64 : acc_var;

    always_comb
    begin
        phase_next       = phase_reg;
        fbp_next         = fbp_reg;
        vbl_next         = vbl_reg;
        acc_next         = acc_reg;
        entries_next     = entries_reg;
        entry_idx_next   = entry_idx_reg;
        script_left_next = script_left_reg;
        script_pos_next  = script_pos_reg;
        seen_next        = seen_reg;
        err_next         = err_reg;
        fres_valid       = 1'b0;
        fres             = '{kind: tsp_pkg::KIND_VERSION, value: 64'd0, entry: 32'd0,
                             bytepos: 32'd0, status: tsp_pkg::ST_OK, eor: 1'b0};
        eres             = '{kind: tsp_pkg::KIND_END, value: 64'd0, entry: 32'd0,
                             bytepos: 32'd0, status: tsp_pkg::ST_OK, eor: 1'b1};

        if (fire)
        begin
            if (seen_reg < tsp_pkg::SEEN_MAX)
            begin
                seen_next = seen_reg + 4'd1;
            end

            // Accumulator and byte position for the multi-byte fields.
            case (phase_reg)
                tsp_pkg::PH_VERSION, tsp_pkg::PH_OUT_INDEX, tsp_pkg::PH_SEQUENCE,
                tsp_pkg::PH_AMOUNT, tsp_pkg::PH_LOCK:
                begin
                    if (fix_done)
                    begin
                        acc_next = 64'd0;
                        fbp_next = 4'd0;
                    end
                    else
                    begin
                        acc_next = acc_fixed;
                        fbp_next = fbp_inc;
                    end
                end
                tsp_pkg::PH_IN_COUNT, tsp_pkg::PH_SIG_LEN, tsp_pkg::PH_OUT_COUNT,
                tsp_pkg::PH_PK_LEN:
                begin
                    if (fbp_reg == 4'd0)
                    begin
                        if (!var_done)
                        begin
                            acc_next = 64'd0;
                            fbp_next = 4'd1;
                            if (byte_reg == tsp_pkg::VARINT_MARK2)
                            begin
                                vbl_next = 4'd2;
                            end
                            else if (byte_reg == tsp_pkg::VARINT_MARK4)
                            begin
                                vbl_next = 4'd4;
                            end
                            else
                            begin
                                vbl_next = 4'd8;
                            end
                        end
                    end
                    else
                    begin
                        vbl_next = vbl_reg - 4'd1;
                        if (var_done)
                        begin
                            acc_next = 64'd0;
                            fbp_next = 4'd0;
                        end
                        else
                        begin
                            acc_next = acc_var;
                            fbp_next = fbp_inc;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            case (phase_reg)
                tsp_pkg::PH_VERSION:
                begin
                    if (fix_done)
                    begin
                        fres_valid = 1'b1;
                        fres.kind  = tsp_pkg::KIND_VERSION;
                        fres.value = acc_fixed;
                        phase_next = tsp_pkg::PH_IN_COUNT;
                    end
                end
                tsp_pkg::PH_IN_COUNT, tsp_pkg::PH_OUT_COUNT:
                begin
                    if (var_done)
                    begin
                        if (tsp_pkg::over_bound(var_value, tsp_pkg::COUNT_BITS))
                        begin
                            err_next   = 1'b1;
                            phase_next = tsp_pkg::PH_ERROR;
                        end
                        else
                        begin
                            fres_valid     = 1'b1;
                            fres.value     = var_value;
                            entries_next   = var_value[tsp_pkg::COUNT_BITS-1:0];
                            entry_idx_next = 32'd0;
                            if (phase_reg == tsp_pkg::PH_IN_COUNT)
                            begin
                                fres.kind       = tsp_pkg::KIND_IN_COUNT;
                                script_pos_next = 32'd0;
                                phase_next      = (var_value == 64'd0) ? tsp_pkg::PH_OUT_COUNT
                                                                       : tsp_pkg::PH_HASH;
                            end
                            else
                            begin
                                fres.kind  = tsp_pkg::KIND_OUT_COUNT;
                                phase_next = (var_value == 64'd0) ? tsp_pkg::PH_LOCK
                                                                  : tsp_pkg::PH_AMOUNT;
                            end
                        end
                    end
                end
                tsp_pkg::PH_HASH:
                begin
                    fres_valid   = 1'b1;
                    fres.kind    = tsp_pkg::KIND_HASH;
                    fres.value   = b64;
                    fres.entry   = entry_idx_reg;
                    fres.bytepos = script_pos_reg;
                    if (script_pos_reg == 32'(tsp_pkg::HASH_BYTES - 1))
                    begin
                        script_pos_next = 32'd0;
                        phase_next      = tsp_pkg::PH_OUT_INDEX;
                    end
                    else
                    begin
                        script_pos_next = script_pos_reg + 32'd1;
                    end
                end
                tsp_pkg::PH_OUT_INDEX, tsp_pkg::PH_AMOUNT:
                begin
                    if (fix_done)
                    begin
                        fres_valid = 1'b1;
                        fres.value = acc_fixed;
                        fres.entry = entry_idx_reg;
                        if (phase_reg == tsp_pkg::PH_OUT_INDEX)
                        begin
                            fres.kind  = tsp_pkg::KIND_OUT_INDEX;
                            phase_next = tsp_pkg::PH_SIG_LEN;
                        end
                        else
                        begin
                            fres.kind  = tsp_pkg::KIND_AMOUNT;
                            phase_next = tsp_pkg::PH_PK_LEN;
                        end
                    end
                end
                tsp_pkg::PH_SIG_LEN, tsp_pkg::PH_PK_LEN:
                begin
                    if (var_done)
                    begin
                        if (tsp_pkg::over_bound(var_value, tsp_pkg::LEN_BITS))
                        begin
                            err_next   = 1'b1;
                            phase_next = tsp_pkg::PH_ERROR;
                        end
                        else
                        begin
                            fres_valid       = 1'b1;
                            fres.value       = var_value;
                            fres.entry       = entry_idx_reg;
                            script_left_next = var_value[tsp_pkg::LEN_BITS-1:0];
                            script_pos_next  = 32'd0;
                            if (phase_reg == tsp_pkg::PH_SIG_LEN)
                            begin
                                fres.kind  = tsp_pkg::KIND_SIG_LEN;
                                phase_next = (var_value == 64'd0) ? tsp_pkg::PH_SEQUENCE
                                                                  : tsp_pkg::PH_SIG_BYTES;
                            end
                            else
                            begin
                                fres.kind = tsp_pkg::KIND_PK_LEN;
                                if (var_value == 64'd0)
                                begin
                                    // Empty script closes the output entry at once.
                                    entry_idx_next = entry_idx_reg + 32'd1;
                                    entries_next   = entries_reg - tsp_pkg::COUNT_BITS'(1);
                                    phase_next     = (entries_reg == tsp_pkg::COUNT_BITS'(1))
                                                     ? tsp_pkg::PH_LOCK : tsp_pkg::PH_AMOUNT;
                                end
                                else
                                begin
                                    phase_next = tsp_pkg::PH_PK_BYTES;
                                end
                            end
                        end
                    end
                end
                tsp_pkg::PH_SIG_BYTES, tsp_pkg::PH_PK_BYTES:
                begin
                    fres_valid       = 1'b1;
                    fres.value       = b64;
                    fres.entry       = entry_idx_reg;
                    fres.bytepos     = script_pos_reg;
                    script_pos_next  = script_pos_reg + 32'd1;
                    script_left_next = script_left_reg - tsp_pkg::LEN_BITS'(1);
                    if (phase_reg == tsp_pkg::PH_SIG_BYTES)
                    begin
                        fres.kind = tsp_pkg::KIND_SIG_BYTE;
                        if (script_left_reg == tsp_pkg::LEN_BITS'(1))
                        begin
                            phase_next = tsp_pkg::PH_SEQUENCE;
                        end
                    end
                    else
                    begin
                        fres.kind = tsp_pkg::KIND_PK_BYTE;
                        if (script_left_reg == tsp_pkg::LEN_BITS'(1))
                        begin
                            entry_idx_next = entry_idx_reg + 32'd1;
                            entries_next   = entries_reg - tsp_pkg::COUNT_BITS'(1);
                            phase_next     = (entries_reg == tsp_pkg::COUNT_BITS'(1))
                                             ? tsp_pkg::PH_LOCK : tsp_pkg::PH_AMOUNT;
                        end
                    end
                end
                tsp_pkg::PH_SEQUENCE:
                begin
                    if (fix_done)
                    begin
                        fres_valid      = 1'b1;
                        fres.kind       = tsp_pkg::KIND_SEQUENCE;
                        fres.value      = acc_fixed;
                        fres.entry      = entry_idx_reg;
                        entry_idx_next  = entry_idx_reg + 32'd1;
                        entries_next    = entries_reg - tsp_pkg::COUNT_BITS'(1);
                        script_pos_next = 32'd0;
                        phase_next      = (entries_reg == tsp_pkg::COUNT_BITS'(1))
                                          ? tsp_pkg::PH_OUT_COUNT : tsp_pkg::PH_HASH;
                    end
                end
                tsp_pkg::PH_LOCK:
                begin
                    if (fix_done)
                    begin
                        fres_valid = 1'b1;
                        fres.kind  = tsp_pkg::KIND_LOCK;
                        fres.value = acc_fixed;
                        phase_next = tsp_pkg::PH_DONE;
                    end
                end
                default:
                begin
                    // Done and error phases ignore further bytes.
                end
            endcase

            if (last_reg)
            begin
                if (seen_next < tsp_pkg::MIN_BYTES)
                begin
                    eres.status = tsp_pkg::ST_SHORT;
                end
                else if (err_next)
                begin
                    eres.status = tsp_pkg::ST_OVERSIZE;
                end
                else if (phase_next != tsp_pkg::PH_DONE)
                begin
                    eres.status = tsp_pkg::ST_TRUNCATED;
                end
                else
                begin
                    eres.status = tsp_pkg::ST_OK;
                end

                // Back to the start for the next transaction.
                phase_next       = tsp_pkg::PH_VERSION;
                fbp_next         = 4'd0;
                vbl_next         = 4'd0;
                acc_next         = 64'd0;
                entries_next     = '0;
                entry_idx_next   = 32'd0;
                script_left_next = '0;
                script_pos_next  = 32'd0;
                seen_next        = 4'd0;
                err_next         = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= tsp_pkg::PH_VERSION;
            fbp_reg         <= 4'd0;
            vbl_reg         <= 4'd0;
            acc_reg         <= 64'd0;
            entries_reg     <= '0;
            entry_idx_reg   <= 32'd0;
            script_left_reg <= '0;
            script_pos_reg  <= 32'd0;
            seen_reg        <= 4'd0;
            err_reg         <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            fbp_reg         <= fbp_next;
            vbl_reg         <= vbl_next;
            acc_reg         <= acc_next;
            entries_reg     <= entries_next;
            entry_idx_reg   <= entry_idx_next;
            script_left_reg <= script_left_next;
            script_pos_reg  <= script_pos_next;
            seen_reg        <= seen_next;
            err_reg         <= err_next;
        end
    end

    // Result queue: the field result goes first, the end result after it.
    assign push_n = {1'b0, fire && fres_valid} + {1'b0, fire && last_reg};
    assign pop    = field_valid && !field_stall;

    always_ff @(posedge clk)
    begin
        if (fire && fres_valid)
        begin
            fifo_mem[wp_reg] <= fres;
            if (last_reg)
            begin
                fifo_mem[ptr_inc(wp_reg)] <= eres;
            end
        end
        else if (fire && last_reg)
        begin
            fifo_mem[wp_reg] <= eres;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push_n == 2'd2)
            begin
                wp_reg <= ptr_inc(ptr_inc(wp_reg));
            end
            else if (push_n == 2'd1)
            begin
                wp_reg <= ptr_inc(wp_reg);
            end
            if (pop)
            begin
                rp_reg <= ptr_inc(rp_reg);
            end
            count_reg <= count_reg + tsp_pkg::CNT_W'(push_n) - tsp_pkg::CNT_W'(pop);
        end
    end

    assign head         = fifo_mem[rp_reg];
    assign field_valid  = (count_reg != '0);
    assign field_kind   = head.kind;
    assign field_value  = head.value;
    assign entry_number = head.entry;
    assign byte_number  = head.bytepos;
    assign status       = head.status;
    assign end_of_run   = head.eor;

    // The queue never holds more results than it has slots.
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= tsp_pkg::CNT_W'(tsp_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    // A parsed byte with a nearly full queue must hold off new bytes.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && count_reg > tsp_pkg::CNT_W'(tsp_pkg::FIFO_DEPTH - 2)) |-> byte_stall)
        else $error("byte accepted without queue room");

    // The closing byte of a transaction returns the parser to its start.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && last_reg) |=> (phase_reg == tsp_pkg::PH_VERSION && seen_reg == 4'd0
                                && !err_reg && fbp_reg == 4'd0))
        else $error("parser not restarted after end of transaction");

    // The end marker travels only with the end kind.
    a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (field_valid && end_of_run) |-> (field_kind == tsp_pkg::KIND_END))
        else $error("end marker on a field result");

    // An oversize error leaves the parser in its error phase.
    a_error_phase: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> (phase_reg == tsp_pkg::PH_ERROR))
        else $error("error flag outside error phase");

endmodule
